// ----- design/rppt_pkg.sv -----
// Package for the rigid pose point transform: fixed widths, the register map
// and the structs that carry matrix rows and split operands between modules.
// No dependencies.
package rppt_pkg;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 32;
  localparam int PT_W       = 32;
  localparam int Q_W        = 16;
  localparam int QN_W       = Q_W + 1;
  localparam int QP_W       = 2 * QN_W;
  localparam int COEF_W     = 34;
  localparam int DIFF_W     = PT_W + 1;
  localparam int LO_W       = 16;
  localparam int HI_W       = DIFF_W - LO_W;
  localparam int PROD_W     = COEF_W + HI_W;
  localparam int ACC_W      = PROD_W + 2;
  localparam int ROUND_SH   = 14;
  localparam int RES_W      = ACC_W - ROUND_SH + 1;

  localparam logic signed [ACC_W-1:0] HALF_LSB = ACC_W'(64'sd536870912);
  localparam logic [15:0] ROT_W_RESET = 16'h7fff;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_ROT_W    = 3'd0,
    REG_ROT_X    = 3'd1,
    REG_ROT_Y    = 3'd2,
    REG_ROT_Z    = 3'd3,
    REG_OFFSET_X = 3'd4,
    REG_OFFSET_Y = 3'd5,
    REG_OFFSET_Z = 3'd6,
    REG_INVERSE  = 3'd7
  } cfg_idx_t;

  typedef logic signed [COEF_W-1:0] coef_t;

  typedef struct packed {
    coef_t c0;
    coef_t c1;
    coef_t c2;
  } coef_row_t;

  typedef struct packed {
    logic signed [HI_W-1:0] hi;
    logic [LO_W-1:0]        lo;
  } opnd_t;

  typedef struct packed {
    opnd_t v0;
    opnd_t v1;
    opnd_t v2;
  } opnd_vec_t;

endpackage

// ----- design/rigid_pose_point_transform_unit.sv -----
// Top level of the rigid pose point transform: register file, quaternion
// products, matrix coefficients, three row units and the saturating output.
// Depends on rppt_pkg and rppt_dot_row.
//
// Each transfer on the input channel carries one Q15.16 point. Forward mode
// returns offset + R(q) * point; inverse mode returns R(conj q) * (point -
// offset). Every component is clipped to 32 bits and out_saturated flags a
// clip. The quaternion is used as written, without renormalization.
// The pose registers are written through the cfg port, one per cycle; the
// user must write them only while no point is in flight, and the block does
// not enforce this. The block is a six-stage pipeline, and one point can be
// accepted in every cycle while no result is stalled. A valid bit travels
// with each stage. When the receiver holds out_ready low with a result
// waiting, the whole pipeline holds and in_ready drops in the same cycle;
// nothing is lost or repeated. Synchronous reset empties the pipeline and
// loads the identity pose in forward mode.
module rigid_pose_point_transform_unit (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  cfg_we,
  input  logic [rppt_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  logic [rppt_pkg::CFG_DATA_W-1:0]       cfg_wdata,
  input  logic                                  in_valid,
  output logic                                  in_ready,
  input  logic signed [rppt_pkg::PT_W-1:0]      in_point_x,
  input  logic signed [rppt_pkg::PT_W-1:0]      in_point_y,
  input  logic signed [rppt_pkg::PT_W-1:0]      in_point_z,
  output logic                                  out_valid,
  input  logic                                  out_ready,
  output logic signed [rppt_pkg::PT_W-1:0]      out_x,
  output logic signed [rppt_pkg::PT_W-1:0]      out_y,
  output logic signed [rppt_pkg::PT_W-1:0]      out_z,
  output logic                                  out_saturated
);
  import rppt_pkg::*;

  localparam int NSTAGE = 6;

  logic signed [Q_W-1:0]  rot_w_r, rot_x_r, rot_y_r, rot_z_r;
  logic signed [PT_W-1:0] off_x_r, off_y_r, off_z_r;
  logic                   inv_r;
  logic [NSTAGE-1:0]      vld_r;
  logic                   en;

  logic signed [QN_W-1:0] qw, qx, qy, qz;
  logic signed [QP_W-1:0] ww_r, xx_r, yy_r, zz_r, xy_r, xz_r, yz_r, wx_r, wy_r, wz_r;
  logic signed [QP_W-1:0] ww_nxt, xx_nxt, yy_nxt, zz_nxt, xy_nxt;
  logic signed [QP_W-1:0] xz_nxt, yz_nxt, wx_nxt, wy_nxt, wz_nxt;
  logic signed [DIFF_W-1:0] dx_r, dy_r, dz_r, dx_nxt, dy_nxt, dz_nxt;

  coef_row_t row0_r, row1_r, row2_r, row0_nxt, row1_nxt, row2_nxt;
  opnd_vec_t opnd_r, opnd_nxt;

  logic signed [ACC_W-1:0] acc0, acc1, acc2;
  logic signed [RES_W-1:0] res0, res1, res2;
  logic [2:0]              hi_clip, lo_clip;
  logic signed [PT_W-1:0]  ox_r, oy_r, oz_r, ox_nxt, oy_nxt, oz_nxt;
  logic                    sat_r, sat_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rot_w_r <= ROT_W_RESET;
      rot_x_r <= '0;
      rot_y_r <= '0;
      rot_z_r <= '0;
      off_x_r <= '0;
      off_y_r <= '0;
      off_z_r <= '0;
      inv_r   <= 1'b0;
    end else if (cfg_we) begin
      case (cfg_idx_t'(cfg_index))
        REG_ROT_W:    rot_w_r <= cfg_wdata[Q_W-1:0];
        REG_ROT_X:    rot_x_r <= cfg_wdata[Q_W-1:0];
        REG_ROT_Y:    rot_y_r <= cfg_wdata[Q_W-1:0];
        REG_ROT_Z:    rot_z_r <= cfg_wdata[Q_W-1:0];
        REG_OFFSET_X: off_x_r <= cfg_wdata[PT_W-1:0];
        REG_OFFSET_Y: off_y_r <= cfg_wdata[PT_W-1:0];
        REG_OFFSET_Z: off_z_r <= cfg_wdata[PT_W-1:0];
        REG_INVERSE:  inv_r   <= cfg_wdata[0];
        default: ;
      endcase
    end
  end

  assign en       = !vld_r[NSTAGE-1] || out_ready;
  assign in_ready = en;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[NSTAGE-2:0], in_valid};
    end
  end

  // The conjugate negates the vector part; a component of -1.0 becomes +1.0 exactly.
  always_comb begin
    qw = QN_W'(rot_w_r);
    qx = inv_r ? -QN_W'(rot_x_r) : QN_W'(rot_x_r);
    qy = inv_r ? -QN_W'(rot_y_r) : QN_W'(rot_y_r);
    qz = inv_r ? -QN_W'(rot_z_r) : QN_W'(rot_z_r);
    ww_nxt = QP_W'(qw) * QP_W'(qw);
    xx_nxt = QP_W'(qx) * QP_W'(qx);
    yy_nxt = QP_W'(qy) * QP_W'(qy);
    zz_nxt = QP_W'(qz) * QP_W'(qz);
    xy_nxt = QP_W'(qx) * QP_W'(qy);
    xz_nxt = QP_W'(qx) * QP_W'(qz);
    yz_nxt = QP_W'(qy) * QP_W'(qz);
    wx_nxt = QP_W'(qw) * QP_W'(qx);
    wy_nxt = QP_W'(qw) * QP_W'(qy);
    wz_nxt = QP_W'(qw) * QP_W'(qz);
    dx_nxt = inv_r ? DIFF_W'(in_point_x) - DIFF_W'(off_x_r) : DIFF_W'(in_point_x);
    dy_nxt = inv_r ? DIFF_W'(in_point_y) - DIFF_W'(off_y_r) : DIFF_W'(in_point_y);
    dz_nxt = inv_r ? DIFF_W'(in_point_z) - DIFF_W'(off_z_r) : DIFF_W'(in_point_z);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ww_r <= ww_nxt;
      xx_r <= xx_nxt;
      yy_r <= yy_nxt;
      zz_r <= zz_nxt;
      xy_r <= xy_nxt;
      xz_r <= xz_nxt;
      yz_r <= yz_nxt;
      wx_r <= wx_nxt;
      wy_r <= wy_nxt;
      wz_r <= wz_nxt;
      dx_r <= dx_nxt;
      dy_r <= dy_nxt;
      dz_r <= dz_nxt;
    end
  end

  always_comb begin
    row0_nxt.c0 = COEF_W'(ww_r) + COEF_W'(xx_r) - COEF_W'(yy_r) - COEF_W'(zz_r);
    row0_nxt.c1 = (COEF_W'(xy_r) - COEF_W'(wz_r)) <<< 1;
    row0_nxt.c2 = (COEF_W'(xz_r) + COEF_W'(wy_r)) <<< 1;
    row1_nxt.c0 = (COEF_W'(xy_r) + COEF_W'(wz_r)) <<< 1;
    row1_nxt.c1 = COEF_W'(ww_r) - COEF_W'(xx_r) + COEF_W'(yy_r) - COEF_W'(zz_r);
    row1_nxt.c2 = (COEF_W'(yz_r) - COEF_W'(wx_r)) <<< 1;
    row2_nxt.c0 = (COEF_W'(xz_r) - COEF_W'(wy_r)) <<< 1;
    row2_nxt.c1 = (COEF_W'(yz_r) + COEF_W'(wx_r)) <<< 1;
    row2_nxt.c2 = COEF_W'(ww_r) - COEF_W'(xx_r) - COEF_W'(yy_r) + COEF_W'(zz_r);
    opnd_nxt.v0.hi = dx_r[DIFF_W-1:LO_W];
    opnd_nxt.v0.lo = dx_r[LO_W-1:0];
    opnd_nxt.v1.hi = dy_r[DIFF_W-1:LO_W];
    opnd_nxt.v1.lo = dy_r[LO_W-1:0];
    opnd_nxt.v2.hi = dz_r[DIFF_W-1:LO_W];
    opnd_nxt.v2.lo = dz_r[LO_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (en) begin
      row0_r <= row0_nxt;
      row1_r <= row1_nxt;
      row2_r <= row2_nxt;
      opnd_r <= opnd_nxt;
    end
  end

  rppt_dot_row u_row0 (.clk(clk), .en(en), .coef(row0_r), .opnd(opnd_r), .acc(acc0));
  rppt_dot_row u_row1 (.clk(clk), .en(en), .coef(row1_r), .opnd(opnd_r), .acc(acc1));
  rppt_dot_row u_row2 (.clk(clk), .en(en), .coef(row2_r), .opnd(opnd_r), .acc(acc2));

  always_comb begin
    res0 = RES_W'(acc0 >>> ROUND_SH) + (inv_r ? RES_W'(0) : RES_W'(off_x_r));
    res1 = RES_W'(acc1 >>> ROUND_SH) + (inv_r ? RES_W'(0) : RES_W'(off_y_r));
    res2 = RES_W'(acc2 >>> ROUND_SH) + (inv_r ? RES_W'(0) : RES_W'(off_z_r));
    hi_clip[0] = !res0[RES_W-1] && (|res0[RES_W-2:PT_W-1]);
    hi_clip[1] = !res1[RES_W-1] && (|res1[RES_W-2:PT_W-1]);
    hi_clip[2] = !res2[RES_W-1] && (|res2[RES_W-2:PT_W-1]);
    lo_clip[0] = res0[RES_W-1] && !(&res0[RES_W-2:PT_W-1]);
    lo_clip[1] = res1[RES_W-1] && !(&res1[RES_W-2:PT_W-1]);
    lo_clip[2] = res2[RES_W-1] && !(&res2[RES_W-2:PT_W-1]);
    ox_nxt = hi_clip[0] ? {1'b0, {(PT_W-1){1'b1}}} :
             lo_clip[0] ? {1'b1, {(PT_W-1){1'b0}}} : res0[PT_W-1:0];
    oy_nxt = hi_clip[1] ? {1'b0, {(PT_W-1){1'b1}}} :
             lo_clip[1] ? {1'b1, {(PT_W-1){1'b0}}} : res1[PT_W-1:0];
    oz_nxt = hi_clip[2] ? {1'b0, {(PT_W-1){1'b1}}} :
             lo_clip[2] ? {1'b1, {(PT_W-1){1'b0}}} : res2[PT_W-1:0];
    sat_nxt = |(hi_clip | lo_clip);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ox_r  <= ox_nxt;
      oy_r  <= oy_nxt;
      oz_r  <= oz_nxt;
      sat_r <= sat_nxt;
    end
  end

  assign out_valid     = vld_r[NSTAGE-1];
  assign out_x         = ox_r;
  assign out_y         = oy_r;
  assign out_z         = oz_r;
  assign out_saturated = sat_r;

endmodule

// ----- design/rppt_dot_row.sv -----
// One row of the rotation: three registered stages that multiply a matrix row
// by the split operand vector, sum the partial products and add the half
// LSB for the later rounding shift to Q.16. Depends on rppt_pkg.
module rppt_dot_row (
  input  logic                              clk,
  input  logic                              en,
  input  rppt_pkg::coef_row_t               coef,
  input  rppt_pkg::opnd_vec_t               opnd,
  output logic signed [rppt_pkg::ACC_W-1:0] acc
);
  import rppt_pkg::*;

  logic signed [PROD_W-1:0] ph0_r, ph1_r, ph2_r;
  logic signed [PROD_W-1:0] pl0_r, pl1_r, pl2_r;
  logic signed [PROD_W-1:0] ph0_nxt, ph1_nxt, ph2_nxt;
  logic signed [PROD_W-1:0] pl0_nxt, pl1_nxt, pl2_nxt;
  logic signed [ACC_W-1:0]  shi_r, tlo_r, acc_r;
  logic signed [ACC_W-1:0]  shi_nxt, tlo_nxt, acc_nxt;

  always_comb begin
    ph0_nxt = PROD_W'(coef.c0) * PROD_W'($signed(opnd.v0.hi));
    ph1_nxt = PROD_W'(coef.c1) * PROD_W'($signed(opnd.v1.hi));
    ph2_nxt = PROD_W'(coef.c2) * PROD_W'($signed(opnd.v2.hi));
    pl0_nxt = PROD_W'(coef.c0) * PROD_W'($signed({1'b0, opnd.v0.lo}));
    pl1_nxt = PROD_W'(coef.c1) * PROD_W'($signed({1'b0, opnd.v1.lo}));
    pl2_nxt = PROD_W'(coef.c2) * PROD_W'($signed({1'b0, opnd.v2.lo}));
    shi_nxt = ACC_W'(ph0_r) + ACC_W'(ph1_r) + ACC_W'(ph2_r);
    tlo_nxt = ACC_W'(pl0_r) + ACC_W'(pl1_r) + ACC_W'(pl2_r) + HALF_LSB;
    acc_nxt = shi_r + (tlo_r >>> LO_W);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ph0_r <= ph0_nxt;
      ph1_r <= ph1_nxt;
      ph2_r <= ph2_nxt;
      pl0_r <= pl0_nxt;
      pl1_r <= pl1_nxt;
      pl2_r <= pl2_nxt;
      shi_r <= shi_nxt;
      tlo_r <= tlo_nxt;
      acc_r <= acc_nxt;
    end
  end

  assign acc = acc_r;

endmodule

// ----- design/rppt_checker.sv -----
// Port-level checks for the rigid pose point transform and the bind that
// attaches them to rigid_pose_point_transform_unit. Depends on rppt_pkg.
module rppt_checker (
  input logic                             clk,
  input logic                             rst_n,
  input logic                             in_valid,
  input logic                             in_ready,
  input logic                             out_valid,
  input logic                             out_ready,
  input logic signed [rppt_pkg::PT_W-1:0] out_x,
  input logic signed [rppt_pkg::PT_W-1:0] out_y,
  input logic signed [rppt_pkg::PT_W-1:0] out_z,
  input logic                             out_saturated
);
  import rppt_pkg::*;

  // A result that is not taken stays on the port unchanged.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_x) && $stable(out_y)
      && $stable(out_z) && $stable(out_saturated))
    else $error("result changed while stalled");

  // A stalled result must block new input transfers.
  a_stall_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |-> !in_ready)
    else $error("input taken while output stalled");

  // The saturation flag comes only with a component at a rail.
  a_sat_at_rail: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_saturated |->
      out_x == 32'sh7fffffff || out_x == 32'sh80000000 ||
      out_y == 32'sh7fffffff || out_y == 32'sh80000000 ||
      out_z == 32'sh7fffffff || out_z == 32'sh80000000)
    else $error("saturation flag without a clipped component");

  // Reset empties the pipeline.
  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result present right after reset");

endmodule

bind rigid_pose_point_transform_unit rppt_checker u_rppt_checker (
  .clk(clk),
  .rst_n(rst_n),
  .in_valid(in_valid),
  .in_ready(in_ready),
  .out_valid(out_valid),
  .out_ready(out_ready),
  .out_x(out_x),
  .out_y(out_y),
  .out_z(out_z),
  .out_saturated(out_saturated)
);
